// ----- sv/dtt_pkg.sv -----
// shared types, codes and sizes of the connection deadline timer table
`default_nettype none

package dtt_pkg;

   localparam int TIMERS    = 32;
   localparam int TIME_BITS = 32;
   localparam int SLOT_BITS = (TIMERS > 1) ? $clog2(TIMERS) : 1;

   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 40;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [SLOT_BITS-1:0] slot_type;

   localparam time_type SIGN_BIT = time_type'(1) << (TIME_BITS - 1);

   // request kinds
   localparam logic [1:0] REQ_ARM     = 2'd0;
   localparam logic [1:0] REQ_DISARM  = 2'd1;
   localparam logic [1:0] REQ_NEAREST = 2'd2;
   localparam logic [1:0] REQ_EXPIRE  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_NOT_ARMED = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic     start;
      logic     due_only;
      time_type now;
   } scan_cmd_type;

   typedef struct packed {
      logic     done;
      logic     found;
      logic     multi;
      slot_type slot;
      time_type diff;
   } scan_res_type;

   typedef struct packed {
      logic     arm_en;
      slot_type arm_slot;
      time_type arm_deadline;
      logic     clr_en;
      slot_type clr_slot;
   } tbl_wr_type;

   typedef struct packed {
      logic     en;
      slot_type addr;
   } tbl_rd_type;

   typedef struct packed {
      logic     armed;
      time_type deadline;
   } tbl_rdata_type;

endpackage

`default_nettype wire

// ----- sv/dtt_table.sv -----
// deadline memory and armed bits of the timer table
`default_nettype none

module dtt_table (
   input  wire                          clock,
   input  wire                          reset,
   input  dtt_pkg::tbl_wr_type          wr,
   input  dtt_pkg::tbl_rd_type          rd,
   output dtt_pkg::tbl_rdata_type       rdata,
   output logic [dtt_pkg::TIMERS-1:0]   armed
);
   import dtt_pkg::*;

   time_type            deadline_ff [TIMERS];
   logic [TIMERS-1:0]   armed_ff;
   logic [TIMERS-1:0]   armed_in;
   tbl_rdata_type       rdata_ff;

   always_comb begin
      armed_in = armed_ff;
      if (wr.arm_en) begin
         armed_in[wr.arm_slot] = 1'b1;
      end
      if (wr.clr_en) begin
         armed_in[wr.clr_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   // synchronous memory, one write and one read port
   always_ff @(posedge clock) begin
      if (wr.arm_en) begin
         deadline_ff[wr.arm_slot] <= wr.arm_deadline;
      end
      if (rd.en) begin
         rdata_ff.deadline <= deadline_ff[rd.addr];
         rdata_ff.armed    <= armed_ff[rd.addr];
      end
   end

   assign rdata = rdata_ff;
   assign armed = armed_ff;

endmodule

`default_nettype wire

// ----- sv/dtt_scan.sv -----
// sequential scan over all slots for the earliest (optionally due) deadline
`default_nettype none

module dtt_scan (
   input  wire                     clock,
   input  wire                     reset,
   input  dtt_pkg::scan_cmd_type   cmd,
   output dtt_pkg::tbl_rd_type     rd,
   input  dtt_pkg::tbl_rdata_type  rdata,
   output dtt_pkg::scan_res_type   res
);
   import dtt_pkg::*;

   localparam slot_type LAST_SLOT = slot_type'(TIMERS - 1);

   logic      issuing_ff, issuing_in;
   slot_type  issue_idx_ff, issue_idx_in;
   logic      vld_ff, vld_in;
   slot_type  cmp_idx_ff, cmp_idx_in;
   logic      cmp_last_ff, cmp_last_in;
   logic      done_ff, done_in;
   logic      found_ff, found_in;
   logic      multi_ff, multi_in;
   slot_type  best_slot_ff, best_slot_in;
   time_type  best_diff_ff, best_diff_in;
   logic      due_only_ff, due_only_in;
   time_type  now_ff, now_in;

   time_type  diff;
   logic      due;
   logic      cand;

   always_comb begin
      diff = rdata.deadline - now_ff;
      due  = (diff == '0) || diff[TIME_BITS-1];
      cand = rdata.armed && (!due_only_ff || due);

      issuing_in   = issuing_ff;
      issue_idx_in = issue_idx_ff;
      vld_in       = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      cmp_last_in  = 1'b0;
      done_in      = 1'b0;
      found_in     = found_ff;
      multi_in     = multi_ff;
      best_slot_in = best_slot_ff;
      best_diff_in = best_diff_ff;
      due_only_in  = due_only_ff;
      now_in       = now_ff;

      if (cmd.start) begin
         issuing_in   = 1'b1;
         issue_idx_in = '0;
         found_in     = 1'b0;
         multi_in     = 1'b0;
         due_only_in  = cmd.due_only;
         now_in       = cmd.now;
      end else if (issuing_ff) begin
         vld_in      = 1'b1;
         cmp_idx_in  = issue_idx_ff;
         cmp_last_in = (issue_idx_ff == LAST_SLOT);
         if (issue_idx_ff == LAST_SLOT) begin
            issuing_in = 1'b0;
         end else begin
            issue_idx_in = issue_idx_ff + slot_type'(1);
         end
      end

      // compare stage: strict less keeps the lowest slot on equal keys
      if (vld_ff) begin
         if (cand) begin
            if (!found_ff || ((diff ^ SIGN_BIT) < (best_diff_ff ^ SIGN_BIT))) begin
               best_slot_in = cmp_idx_ff;
               best_diff_in = diff;
            end
            if (found_ff) begin
               multi_in = 1'b1;
            end
            found_in = 1'b1;
         end
         if (cmp_last_ff) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff  <= 1'b0;
         vld_ff      <= 1'b0;
         cmp_last_ff <= 1'b0;
         done_ff     <= 1'b0;
         found_ff    <= 1'b0;
         multi_ff    <= 1'b0;
      end else begin
         issuing_ff  <= issuing_in;
         vld_ff      <= vld_in;
         cmp_last_ff <= cmp_last_in;
         done_ff     <= done_in;
         found_ff    <= found_in;
         multi_ff    <= multi_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_slot_ff <= best_slot_in;
      best_diff_ff <= best_diff_in;
      due_only_ff  <= due_only_in;
      now_ff       <= now_in;
   end

   assign rd.en      = issuing_ff && !cmd.start;
   assign rd.addr    = issue_idx_ff;
   assign res.done   = done_ff;
   assign res.found  = found_ff;
   assign res.multi  = multi_ff;
   assign res.slot   = best_slot_ff;
   assign res.diff   = best_diff_ff;

endmodule

`default_nettype wire

// ----- sv/connection_deadline_timer_table.sv -----
// top level of the connection deadline timer table: request control and result register
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser: req_type; tdata: slot, timeout, now
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: status, slot, remaining; tlast: last
//
//  arm and disarm are handled in the transfer cycle, then the result is sent from the emit state
//  one pass over the deadline memory runs through the start, wait and emit states
//  nearest takes the transfer cycle plus one pass
//  expire with k due slots takes the transfer cycle plus max(1, k) passes
//  reset (synchronous) clears the armed bits at once, no clearing pass
//  a result waiting in the output register does not block the next request transfer
`default_nettype none

module connection_deadline_timer_table (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [4:0] slot_id, [36:5] timeout_ms, [68:37] now_ms, [71:69] zero
   input  wire  [dtt_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [1:0] req_type
   input  wire  [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [1:0] status, [6:2] expired_slot, [38:7] remaining_ms, [39] zero
   output logic [dtt_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                               rsp_tlast
);
   import dtt_pkg::*;

   localparam int WIDE_BITS = (TIME_BITS > 32) ? TIME_BITS : 33;
   localparam logic [31:0] REM_ALL = 32'hFFFF_FFFF;

   // control states
   localparam logic [1:0] S_IDLE       = 2'd0;
   localparam logic [1:0] S_SCAN_START = 2'd1;
   localparam logic [1:0] S_SCAN_WAIT  = 2'd2;
   localparam logic [1:0] S_EMIT       = 2'd3;

   logic [1:0]   state_ff, state_in;
   logic [1:0]   kind_ff, kind_in;
   time_type     now_ff, now_in;
   logic [1:0]   pend_status_ff, pend_status_in;
   logic [4:0]   pend_slot_ff, pend_slot_in;
   logic [31:0]  pend_rem_ff, pend_rem_in;
   logic         pend_last_ff, pend_last_in;
   logic         pend_more_ff, pend_more_in;
   logic         any_ff, any_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;

   tbl_wr_type        wr;
   tbl_rd_type        rd;
   tbl_rdata_type     rdata;
   logic [TIMERS-1:0] armed;
   scan_cmd_type      cmd;
   scan_res_type      res;

   logic [1:0]   in_type;
   logic [4:0]   in_slot;
   logic [31:0]  in_tmo;
   logic [31:0]  in_now;
   logic         slot_out;
   slot_type     slot_idx;
   logic         accept;
   logic         out_free;
   logic [WIDE_BITS-1:0] wide_diff;
   logic [31:0]  rem_calc;

   dtt_table u_table (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .rd    (rd),
      .rdata (rdata),
      .armed (armed)
   );

   dtt_scan u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rd    (rd),
      .rdata (rdata),
      .res   (res)
   );

   // request fields
   assign in_type  = req_tuser[1:0];
   assign in_slot  = req_tdata[4:0];
   assign in_tmo   = req_tdata[36:5];
   assign in_now   = req_tdata[68:37];
   assign slot_out = 32'(in_slot) >= TIMERS;
   assign slot_idx = slot_type'(in_slot);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // time left, clamped at zero and saturated to the 32-bit field
   always_comb begin
      wide_diff = WIDE_BITS'(res.diff);
      if (res.diff[TIME_BITS-1]) begin
         rem_calc = '0;
      end else if (wide_diff > WIDE_BITS'(REM_ALL)) begin
         rem_calc = REM_ALL;
      end else begin
         rem_calc = wide_diff[31:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      now_in         = now_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      pend_rem_in    = pend_rem_ff;
      pend_last_in   = pend_last_ff;
      pend_more_in   = pend_more_ff;
      any_in         = any_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;

      wr              = '0;
      cmd.start       = 1'b0;
      cmd.due_only    = (kind_ff == REQ_EXPIRE);
      cmd.now         = now_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in      = in_type;
               now_in       = time_type'(in_now);
               any_in       = 1'b0;
               pend_slot_in = '0;
               pend_rem_in  = '0;
               pend_last_in = 1'b1;
               pend_more_in = 1'b0;
               state_in     = S_EMIT;
               priority if (in_type == REQ_ARM) begin
                  if (in_tmo == '0) begin
                     pend_status_in = ST_INVALID;
                  end else if (slot_out) begin
                     pend_status_in = ST_NOT_ARMED;
                  end else begin
                     // rearm replaces any earlier deadline of the slot
                     wr.arm_en       = 1'b1;
                     wr.arm_slot     = slot_idx;
                     wr.arm_deadline = time_type'(in_now) + time_type'(in_tmo);
                     pend_status_in  = ST_OK;
                  end
               end else if (in_type == REQ_DISARM) begin
                  if (slot_out || !armed[slot_idx]) begin
                     pend_status_in = ST_NOT_ARMED;
                  end else begin
                     wr.clr_en      = 1'b1;
                     wr.clr_slot    = slot_idx;
                     pend_status_in = ST_OK;
                  end
               end else begin
                  state_in = S_SCAN_START;
               end
            end
         end
         S_SCAN_START: begin
            cmd.start = 1'b1;
            state_in  = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: begin
            if (res.done) begin
               pend_slot_in = '0;
               pend_rem_in  = '0;
               pend_last_in = 1'b1;
               pend_more_in = 1'b0;
               state_in     = S_EMIT;
               if (kind_ff == REQ_NEAREST) begin
                  if (res.found) begin
                     pend_status_in = ST_OK;
                     pend_rem_in    = rem_calc;
                  end else begin
                     pend_status_in = ST_EMPTY;
                     pend_rem_in    = REM_ALL;
                  end
               end else begin
                  if (res.found) begin
                     // expired slot leaves the table before the next pass
                     pend_status_in = ST_OK;
                     pend_slot_in   = 5'(res.slot);
                     pend_last_in   = !res.multi;
                     pend_more_in   = res.multi;
                     wr.clr_en      = 1'b1;
                     wr.clr_slot    = res.slot;
                     any_in         = 1'b1;
                  end else begin
                     pend_status_in = ST_EMPTY;
                  end
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, pend_rem_ff, pend_slot_ff, pend_status_ff};
               rsp_last_in  = pend_last_ff;
               state_in     = pend_more_ff ? S_SCAN_START : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         any_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         any_ff       <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      now_ff         <= now_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      pend_rem_ff    <= pend_rem_in;
      pend_last_ff   <= pend_last_in;
      pend_more_ff   <= pend_more_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a finished pass only shows up while control waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      res.done |-> (state_ff == S_SCAN_WAIT))
      else $error("scan finished outside of scan wait");

   // an expired slot is already disarmed when its result is sent
   a_expired_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && kind_ff == REQ_EXPIRE && pend_status_ff == ST_OK)
      |-> !armed[slot_type'(pend_slot_ff)])
      else $error("expired slot still armed");

   // nothing-due result only when the expire request gave no slot yet
   a_empty_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && kind_ff == REQ_EXPIRE && pend_status_ff == ST_EMPTY)
      |-> !any_ff)
      else $error("empty status after expired slots");

endmodule

`default_nettype wire
